### hw/rtl/njtb_pkg.sv
// ----------------------------------------------------------------------------
// njtb_pkg
// Shared types, constants and helpers for the neighbor joining tree builder.
// ----------------------------------------------------------------------------
package njtb_pkg;

  localparam int SLOT_W = 6;
  localparam int CNT_W  = 7;
  localparam int LEN_W  = 32;
  localparam int DEN_W  = 8;

  localparam logic [CNT_W-1:0] TAXA_RESET = 7'd64;
  localparam logic [CNT_W-1:0] TAXA_MIN   = 7'd3;

  // 100000.0 in Q16.16.
  localparam logic [63:0] START_BEST = 64'd6553600000;

  typedef struct packed {
    logic busy;
    logic done;
  } njtb_div_stat_t;

  // Linear address of the lower-triangular pair (hi > lo).
  function automatic logic [11:0] tri_addr(input logic [SLOT_W-1:0] hi,
                                           input logic [SLOT_W-1:0] lo);
    logic [11:0] prod;
    prod = 12'(hi) * 12'(hi - 6'd1);
    return (prod >> 1) + 12'(lo);
  endfunction

endpackage

### hw/rtl/njtb_if.sv
// ----------------------------------------------------------------------------
// njtb interfaces
// Valid/ready channels for matrix entries, join results and configuration.
// ----------------------------------------------------------------------------
interface njtb_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  row_index;
  logic [5:0]  col_index;
  logic [30:0] distance_value;
  logic        final_entry;
  modport source (output valid, row_index, col_index, distance_value, final_entry,
                  input ready);
  modport sink (input valid, row_index, col_index, distance_value, final_entry,
                output ready);
endinterface

interface njtb_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         left_slot;
  logic [5:0]         right_slot;
  logic signed [31:0] left_length;
  logic signed [31:0] right_length;
  logic               last_join;
  modport source (output valid, left_slot, right_slot, left_length, right_length,
                  last_join, input ready);
  modport sink (input valid, left_slot, right_slot, left_length, right_length,
                last_join, output ready);
endinterface

interface njtb_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] taxa_count;
  modport source (output valid, taxa_count, input ready);
  modport sink (input valid, taxa_count, output ready);
endinterface

### hw/rtl/neighbor_joining_tree_builder_core.sv
// ----------------------------------------------------------------------------
// neighbor_joining_tree_builder_core
// Loads a lower-triangular distance matrix and runs neighbor joining on it.
// ----------------------------------------------------------------------------
//  channel     dir  handshake      payload
//  item_in     in   valid/ready    row_index, col_index, distance_value, final_entry
//  result_out  out  valid/ready    left_slot, right_slot, left_length, right_length,
//                                  last_join
//  cfg         in   valid/ready    taxa_count
//
// A non-final entry is stored when accepted; entries stream at one per cycle while loading.
// A final entry starts joining; for n taxa each of the n-2 rounds runs a divergence
// pass, a pair scan over the distance memory, a bit-serial divide and a merge, and
// the root join follows.
// New entries are refused until the root join is loaded into the output register.
// A stalled result only holds the round when the next result is due.
// rst is synchronous and clears control state; the memories are not cleared.
module neighbor_joining_tree_builder_core import njtb_pkg::*; #(
  parameter int MAX_TAXA   = 64,
  parameter int DIST_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  njtb_in_if.sink    item_in,
  njtb_out_if.source result_out,
  njtb_cfg_if.sink   cfg
);

  localparam int DW          = DIST_WIDTH;
  localparam int RW          = DW + 6;
  localparam int KW          = (DW + 8 > 42) ? DW + 8 : 42;
  localparam int DEPTH       = MAX_TAXA * (MAX_TAXA - 1) / 2;
  localparam int AW          = $clog2(DEPTH);
  localparam int SLOT_LIMIT  = (MAX_TAXA < 64) ? MAX_TAXA : 64;

  localparam logic [63:0]          DMAX64 = (64'd1 << (DW - 1)) - 64'd1;
  localparam logic signed [DW+1:0] DMAX_X = (DW+2)'(DMAX64);
  localparam logic signed [DW+1:0] DMIN_X = -DMAX_X - 1;
  localparam logic signed [KW:0]   LMAX_X = (KW+1)'(64'h7fffffff);
  localparam logic signed [KW:0]   LMIN_X = -LMAX_X - 1;
  localparam logic signed [KW-1:0] START  = KW'(START_BEST);

  typedef enum logic [19:0] {
    S_LOAD    = 20'h00001,
    S_DV_A    = 20'h00002,
    S_DV_B    = 20'h00004,
    S_DV_W    = 20'h00008,
    S_DV_WR   = 20'h00010,
    S_SC_INIT = 20'h00020,
    S_SC_A    = 20'h00040,
    S_SC_B    = 20'h00080,
    S_SC_W    = 20'h00100,
    S_SC_K    = 20'h00200,
    S_RS_R    = 20'h00400,
    S_RS_W    = 20'h00800,
    S_RS_S    = 20'h01000,
    S_RS_D    = 20'h02000,
    S_OUT     = 20'h04000,
    S_MG_A    = 20'h08000,
    S_MG_B    = 20'h10000,
    S_MG_C    = 20'h20000,
    S_RT_R    = 20'h40000,
    S_RT_W    = 20'h80000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  taxa;
  logic [CNT_W-1:0]  cnt;
  logic [63:0]       active;
  logic [SLOT_W-1:0] n_last;
  logic [SLOT_W-1:0] ia;
  logic [SLOT_W-1:0] ib;
  logic [SLOT_W-1:0] bi;
  logic [SLOT_W-1:0] bj;
  logic [SLOT_W-1:0] kother;
  logic [CNT_W-1:0]  m2;
  logic              first;

  logic signed [RW-1:0] acc;
  logic signed [KW-1:0] best;
  logic signed [KW-1:0] prod;
  logic signed [KW-1:0] rsum;
  logic signed [KW-1:0] num;
  logic signed [DW-1:0] dij;
  logic signed [DW-1:0] da;

  logic              out_valid;
  logic [SLOT_W-1:0] out_left;
  logic [SLOT_W-1:0] out_right;
  logic [LEN_W-1:0]  out_llen;
  logic [LEN_W-1:0]  out_rlen;
  logic              out_last;
  logic              out_free;
  logic              out_load;

  // Memory ports
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [DW-1:0] st_wdata;
  logic          st_re;
  logic [AW-1:0] st_raddr;
  logic [DW-1:0] st_rdata;

  logic              dv_we;
  logic              dv_re;
  logic [SLOT_W-1:0] dv_ra;
  logic [SLOT_W-1:0] dv_rb;
  logic [RW-1:0]     dv_ra_data;
  logic [RW-1:0]     dv_rb_data;

  logic                 div_start;
  logic signed [KW-1:0] div_quot;
  njtb_div_stat_t       div_stat;

  logic [SLOT_W-1:0] pa;
  logic [SLOT_W-1:0] pb;
  logic [SLOT_W-1:0] p_hi;
  logic [SLOT_W-1:0] p_lo;
  logic [SLOT_W-1:0] m_hi;
  logic [SLOT_W-1:0] m_lo;

  logic                 in_acc;
  logic                 coord_ok;
  logic [63:0]          dext;
  logic [DW-1:0]        load_val;
  logic [CNT_W-1:0]     n_run;
  logic signed [DW-1:0] rd_s;
  logic signed [KW-1:0] key;
  logic signed [DW+1:0] msum;
  logic signed [DW+1:0] mhalf;
  logic [DW-1:0]        mval;
  logic signed [KW:0]   llx;
  logic signed [KW:0]   rlx;
  logic signed [KW:0]   hx;
  logic [LEN_W-1:0]     ll_sat;
  logic [LEN_W-1:0]     rl_sat;
  logic [LEN_W-1:0]     h_sat;

  assign rd_s = $signed(st_rdata);

  assign item_in.ready = (state == S_LOAD);
  assign in_acc        = item_in.valid && item_in.ready;
  assign cfg.ready     = 1'b1;

  assign out_free = !out_valid || result_out.ready;

  // Input entry conditioning.
  assign coord_ok = (item_in.row_index > item_in.col_index) &&
                    ({1'b0, item_in.row_index} < CNT_W'(MAX_TAXA));
  assign dext     = 64'(item_in.distance_value);
  assign load_val = (dext > DMAX64) ? DMAX64[DW-1:0] : dext[DW-1:0];

  always_comb begin
    if (taxa < TAXA_MIN) begin
      n_run = TAXA_MIN;
    end else if (taxa > CNT_W'(SLOT_LIMIT)) begin
      n_run = CNT_W'(SLOT_LIMIT);
    end else begin
      n_run = taxa;
    end
  end

  // Read pair and enables per state.
  always_comb begin
    pa    = ia;
    pb    = ib;
    st_re = 1'b0;
    dv_re = 1'b0;
    dv_ra = ia;
    dv_rb = ib;
    case (state)
      S_DV_B: begin
        st_re = active[ib] && (ib != ia);
      end
      S_SC_B: begin
        st_re = (ib != ia) && active[ib];
        dv_re = st_re;
      end
      S_RS_R: begin
        pa    = bj;
        pb    = bi;
        st_re = 1'b1;
        dv_re = 1'b1;
        dv_ra = bi;
        dv_rb = bj;
      end
      S_MG_A: begin
        pb    = bi;
        st_re = active[ia] && (ia != bi);
      end
      S_MG_B: begin
        pb    = bj;
        st_re = 1'b1;
      end
      S_RT_R: begin
        pa    = bi;
        pb    = kother;
        st_re = 1'b1;
      end
      default: begin
        st_re = 1'b0;
      end
    endcase
  end

  assign p_hi     = (pa > pb) ? pa : pb;
  assign p_lo     = (pa > pb) ? pb : pa;
  assign st_raddr = AW'(tri_addr(p_hi, p_lo));

  // Merge arithmetic: floor of half the sum, saturated to the store width.
  assign m_hi  = (ia > bi) ? ia : bi;
  assign m_lo  = (ia > bi) ? bi : ia;
  assign msum  = (DW+2)'(da) + (DW+2)'(rd_s) - (DW+2)'(dij);
  assign mhalf = msum >>> 1;
  always_comb begin
    if (mhalf > DMAX_X) begin
      mval = DMAX_X[DW-1:0];
    end else if (mhalf < DMIN_X) begin
      mval = DMIN_X[DW-1:0];
    end else begin
      mval = mhalf[DW-1:0];
    end
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = AW'(tri_addr(item_in.row_index, item_in.col_index));
    st_wdata = load_val;
    if (state == S_MG_C) begin
      st_we    = 1'b1;
      st_waddr = AW'(tri_addr(m_hi, m_lo));
      st_wdata = mval;
    end else if (in_acc && coord_ok) begin
      st_we = 1'b1;
    end
  end

  assign dv_we     = (state == S_DV_WR);
  assign div_start = (state == S_RS_S);
  assign key       = prod - rsum;

  // Branch lengths saturated to 32 bits.
  assign llx = (KW+1)'(div_quot);
  assign rlx = (KW+1)'(dij) - llx;
  assign hx  = (KW+1)'(rd_s >>> 1);

  always_comb begin
    ll_sat = (llx > LMAX_X) ? LMAX_X[LEN_W-1:0] :
             (llx < LMIN_X) ? LMIN_X[LEN_W-1:0] : llx[LEN_W-1:0];
    rl_sat = (rlx > LMAX_X) ? LMAX_X[LEN_W-1:0] :
             (rlx < LMIN_X) ? LMIN_X[LEN_W-1:0] : rlx[LEN_W-1:0];
    h_sat  = (hx > LMAX_X) ? LMAX_X[LEN_W-1:0] :
             (hx < LMIN_X) ? LMIN_X[LEN_W-1:0] : hx[LEN_W-1:0];
  end

  assign out_load = ((state == S_OUT) || (state == S_RT_W)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      taxa      <= TAXA_RESET;
      cnt       <= '0;
      active    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        taxa <= cfg.taxa_count;
      end
      out_valid <= out_load || (out_valid && !result_out.ready);
      case (state)
        S_LOAD: begin
          if (in_acc && item_in.final_entry) begin
            for (int k = 0; k < 64; k++) begin
              active[k] <= (CNT_W'(k) < n_run);
            end
            cnt    <= n_run;
            n_last <= SLOT_W'(n_run - 1'b1);
            ia     <= '0;
            state  <= S_DV_A;
          end
        end
        S_DV_A: begin
          if (active[ia]) begin
            acc   <= '0;
            ib    <= '0;
            state <= S_DV_B;
          end else if (ia == n_last) begin
            state <= S_SC_INIT;
          end else begin
            ia <= ia + 1'b1;
          end
        end
        S_DV_B: begin
          if (st_re) begin
            state <= S_DV_W;
          end else if (ib == n_last) begin
            state <= S_DV_WR;
          end else begin
            ib <= ib + 1'b1;
          end
        end
        S_DV_W: begin
          acc <= acc + RW'(rd_s);
          if (ib == n_last) begin
            state <= S_DV_WR;
          end else begin
            ib    <= ib + 1'b1;
            state <= S_DV_B;
          end
        end
        S_DV_WR: begin
          if (ia == n_last) begin
            state <= S_SC_INIT;
          end else begin
            ia    <= ia + 1'b1;
            state <= S_DV_A;
          end
        end
        S_SC_INIT: begin
          m2    <= cnt - 7'd2;
          best  <= START * KW'($signed({1'b0, cnt - 7'd2}));
          first <= 1'b1;
          ia    <= '0;
          state <= S_SC_A;
        end
        S_SC_A: begin
          if (active[ia] && (ia != '0)) begin
            ib    <= '0;
            state <= S_SC_B;
          end else if (ia == n_last) begin
            state <= S_RS_R;
          end else begin
            ia <= ia + 1'b1;
          end
        end
        S_SC_B: begin
          if (ib == ia) begin
            if (ia == n_last) begin
              state <= S_RS_R;
            end else begin
              ia    <= ia + 1'b1;
              state <= S_SC_A;
            end
          end else if (active[ib]) begin
            state <= S_SC_W;
          end else begin
            ib <= ib + 1'b1;
          end
        end
        S_SC_W: begin
          prod  <= KW'(rd_s) * KW'($signed({1'b0, m2}));
          rsum  <= KW'($signed(dv_ra_data)) + KW'($signed(dv_rb_data));
          state <= S_SC_K;
        end
        S_SC_K: begin
          // The first pair scanned is the fallback when nothing beats the start.
          if (key < best) begin
            best <= key;
            bi   <= ib;
            bj   <= ia;
          end else if (first) begin
            bi <= ib;
            bj <= ia;
          end
          first <= 1'b0;
          ib    <= ib + 1'b1;
          state <= S_SC_B;
        end
        S_RS_R: begin
          state <= S_RS_W;
        end
        S_RS_W: begin
          dij   <= rd_s;
          num   <= KW'(rd_s) * KW'($signed({1'b0, m2})) +
                   KW'($signed(dv_ra_data)) - KW'($signed(dv_rb_data));
          state <= S_RS_S;
        end
        S_RS_S: begin
          state <= S_RS_D;
        end
        S_RS_D: begin
          if (div_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_left   <= bi;
            out_right  <= bj;
            out_llen   <= ll_sat;
            out_rlen   <= rl_sat;
            out_last   <= 1'b0;
            active[bj] <= 1'b0;
            cnt        <= cnt - 1'b1;
            ia         <= '0;
            state      <= S_MG_A;
          end
        end
        S_MG_A: begin
          if (st_re) begin
            kother <= ia;
            state  <= S_MG_B;
          end else if (ia == n_last) begin
            ia    <= '0;
            state <= (cnt > 7'd2) ? S_DV_A : S_RT_R;
          end else begin
            ia <= ia + 1'b1;
          end
        end
        S_MG_B: begin
          da    <= rd_s;
          state <= S_MG_C;
        end
        S_MG_C: begin
          if (ia == n_last) begin
            ia    <= '0;
            state <= (cnt > 7'd2) ? S_DV_A : S_RT_R;
          end else begin
            ia    <= ia + 1'b1;
            state <= S_MG_A;
          end
        end
        S_RT_R: begin
          state <= S_RT_W;
        end
        S_RT_W: begin
          if (out_free) begin
            out_left  <= (bi < kother) ? bi : kother;
            out_right <= (bi < kother) ? kother : bi;
            out_llen  <= h_sat;
            out_rlen  <= h_sat;
            out_last  <= 1'b1;
            state     <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.left_slot    = out_left;
  assign result_out.right_slot   = out_right;
  assign result_out.left_length  = $signed(out_llen);
  assign result_out.right_length = $signed(out_rlen);
  assign result_out.last_join    = out_last;

  njtb_dist_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_dist_mem (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  njtb_div_mem #(
    .RW (RW)
  ) u_div_mem (
    .clk     (clk),
    .we      (dv_we),
    .waddr   (ia),
    .wdata   (acc),
    .re      (dv_re),
    .ra_addr (dv_ra),
    .rb_addr (dv_rb),
    .ra_data (dv_ra_data),
    .rb_data (dv_rb_data)
  );

  njtb_floordiv #(
    .NW (KW)
  ) u_floordiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   ({m2, 1'b0}),
    .quot  (div_quot),
    .stat  (div_stat)
  );

`ifndef SYNTH
  // The live slot mask and the live count move together during a run.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> ($countones(active) == 32'(cnt)))
    else $error("active mask and count disagree");

  // A result is loaded only into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || result_out.ready))
    else $error("output register overwritten");

  // The chosen pair is ordered and both slots are live when it is emitted.
  a_pair_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> ((bi < bj) && active[bi] && active[bj]))
    else $error("bad joined pair");

  // The divider is never restarted while it is still working.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");
`endif

endmodule

### hw/rtl/njtb_dist_mem.sv
// ----------------------------------------------------------------------------
// njtb_dist_mem
// Distance store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module njtb_dist_mem #(
  parameter int DEPTH = 2016,
  parameter int AW    = 11,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/njtb_div_mem.sv
// ----------------------------------------------------------------------------
// njtb_div_mem
// Net divergence per slot: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module njtb_div_mem import njtb_pkg::*; #(
  parameter int RW = 38
) (
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  logic [RW-1:0]     wdata,
  input  logic              re,
  input  logic [SLOT_W-1:0] ra_addr,
  input  logic [SLOT_W-1:0] rb_addr,
  output logic [RW-1:0]     ra_data,
  output logic [RW-1:0]     rb_data
);

  logic [RW-1:0] mem [2**SLOT_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      ra_data <= mem[ra_addr];
      rb_data <= mem[rb_addr];
    end
  end

endmodule

### hw/rtl/njtb_floordiv.sv
// ----------------------------------------------------------------------------
// njtb_floordiv
// Bit-serial floor division of a signed numerator by a small positive divisor.
// ----------------------------------------------------------------------------
module njtb_floordiv import njtb_pkg::*; #(
  parameter int NW = 42
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DEN_W-1:0]     den,
  output logic signed [NW-1:0] quot,
  output njtb_div_stat_t       stat
);

  localparam int CW = $clog2(NW);

  logic             busy;
  logic             done;
  logic             neg;
  logic [NW-1:0]    q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [NW-1:0]    adj;

  assign shifted = {rem, q[NW-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        done  <= 1'b0;
        neg   <= num[NW-1];
        q     <= num[NW-1] ? NW'(-num) : NW'(num);
        rem   <= '0;
        den_r <= den;
        cnt   <= '0;
      end else if (busy) begin
        rem  <= ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
        q    <= {q[NW-2:0], ge};
        cnt  <= cnt + 1'b1;
        done <= (cnt == CW'(NW - 1));
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // A negative numerator rounds its magnitude quotient up, then negates.
  assign adj  = q + NW'(rem != '0);
  assign quot = neg ? $signed(-adj) : $signed(q);

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
